/* rtl/aie_pkg.sv */
// Package for the arithmetic instruction execute block.
// Holds the opcode codes and the instruction field widths; no dependencies.

package aie_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned OPCODE_W = 6;
    localparam int unsigned SLOT_W = 5;
    localparam int unsigned COUNT_W = 6;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam opcode_t OP_ADD  = 6'b000000;
    localparam opcode_t OP_ADDI = 6'b000001;
    localparam opcode_t OP_SUB  = 6'b000010;
    localparam opcode_t OP_SUBI = 6'b000011;
    localparam opcode_t OP_MUL  = 6'b000100;
    localparam opcode_t OP_MULI = 6'b000101;

endpackage

/* rtl/arith_instruction_execute.sv */
// Arithmetic execute stage with register file, first-write tracking and counters.
// Depends on aie_pkg for opcodes and field widths.
//
//   Channel  Signals                                  Direction  Beat
//   input    in_valid, in_ready, instr_word           in         one instruction word
//   output   out_valid, out_ready, executed ..        out        one result per instruction
//
// An instruction passes the execute stage register, which takes the register file
// and slot memory reads (registered read ports), then the adder or the 32x32
// multiplier into the output register. A new beat is taken every cycle unless stalled.
// The result and slot of the instruction just ahead are forwarded from bypass registers,
// so back-to-back dependent instructions need no bubble.
// Reset clears the control flops, the register file valid bits, the first-write mask
// and the counters at once; no clearing pass is needed. A stall on the output side holds
// the output register and the execute register, and in_ready falls only when both are full.

module arith_instruction_execute #(
    parameter int REG_COUNT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        instr_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               executed,
    output logic [4:0]         dest_reg,
    output logic signed [31:0] dest_value,
    output logic               first_change,
    output logic [4:0]         change_slot,
    output logic [31:0]        instructions_seen,
    output logic [31:0]        arithmetic_seen
);

    // Index width into the register file; register numbers at or above REG_COUNT
    // read as zero and are never written.
    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [aie_pkg::REG_IDX_W:0] REG_LIMIT = (aie_pkg::REG_IDX_W + 1)'(REG_COUNT);

    // Register file storage: memory plus one valid bit per entry so that an entry
    // never written since reset reads as zero.
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;

    // First-write list: mask bit and slot per register, and the list length.
    logic [REG_COUNT-1:0]         changed_mask_reg;
    logic [aie_pkg::SLOT_W-1:0]   slot_of_reg [REG_COUNT];
    logic [aie_pkg::COUNT_W-1:0]  change_count_reg;
    logic [aie_pkg::COUNT_W-1:0]  change_count_next;

    logic [31:0] instr_total_reg;
    logic [31:0] instr_total_next;
    logic [31:0] arith_total_reg;
    logic [31:0] arith_total_next;

    // Execute stage register.
    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;
    logic [31:0] s1_rs_data_reg;
    logic [31:0] s1_rt_data_reg;
    logic        s1_rs_ok_reg;
    logic        s1_rt_ok_reg;
    logic [aie_pkg::SLOT_W-1:0] s1_slot_reg;

    // Bypass of the most recent register write.
    logic        fwd_valid_reg;
    logic [4:0]  fwd_dest_reg;
    logic [31:0] fwd_value_reg;
    logic [aie_pkg::SLOT_W-1:0] fwd_slot_reg;

    // Output register.
    logic        out_valid_reg;
    logic        executed_reg;
    logic [4:0]  dest_reg_reg;
    logic [31:0] dest_value_reg;
    logic        first_change_reg;
    logic [4:0]  change_slot_reg;
    logic [31:0] instructions_seen_reg;
    logic [31:0] arithmetic_seen_reg;

    logic in_fire;
    logic s1_move;

    // Input side decode for the register file and slot reads.
    aie_pkg::opcode_t  in_op;
    aie_pkg::reg_idx_t in_rs;
    aie_pkg::reg_idx_t in_rt;
    aie_pkg::reg_idx_t in_dest;
    logic [IDX_W-1:0]  in_rs_idx;
    logic [IDX_W-1:0]  in_rt_idx;
    logic [IDX_W-1:0]  in_dest_idx;
    logic              in_rs_in_range;
    logic              in_rt_in_range;

    // Execute stage decode and datapath.
    aie_pkg::opcode_t  op;
    aie_pkg::reg_idx_t s1_rs;
    aie_pkg::reg_idx_t s1_rt;
    aie_pkg::reg_idx_t s1_rd;
    logic [31:0]       imm_ext;
    logic [31:0]       opnd_a;
    logic [31:0]       opnd_rt;
    logic [31:0]       opnd_b;
    logic              is_arith;
    logic              is_imm;
    logic              is_sub;
    logic              is_mul;
    aie_pkg::reg_idx_t dest;
    logic [IDX_W-1:0]  dest_idx;
    logic              dest_in_range;
    logic              done;
    logic [31:0]       sum;
    logic [31:0]       product;
    logic [31:0]       value;
    logic              first;
    logic [4:0]        slot;

    assign in_fire = in_valid && in_ready;
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    assign in_op = instr_word[31:26];
    assign in_rs = instr_word[25:21];
    assign in_rt = instr_word[20:16];
    // Immediate forms write rt, every other form writes rd.
    assign in_dest = (in_op inside {aie_pkg::OP_ADDI, aie_pkg::OP_SUBI, aie_pkg::OP_MULI}) ?
                     in_rt : instr_word[15:11];
    assign in_rs_idx = in_rs[IDX_W-1:0];
    assign in_rt_idx = in_rt[IDX_W-1:0];
    assign in_dest_idx = in_dest[IDX_W-1:0];
    assign in_rs_in_range = ({1'b0, in_rs} < REG_LIMIT);
    assign in_rt_in_range = ({1'b0, in_rt} < REG_LIMIT);

    // Register file and slot read ports, payload of the execute stage.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= instr_word;
            s1_rs_data_reg <= rf_mem[in_rs_idx];
            s1_rt_data_reg <= rf_mem[in_rt_idx];
            s1_rs_ok_reg <= in_rs_in_range && rf_valid_reg[in_rs_idx];
            s1_rt_ok_reg <= in_rt_in_range && rf_valid_reg[in_rt_idx];
            s1_slot_reg <= slot_of_reg[in_dest_idx];
        end
    end

    // Decode of the instruction held in the execute stage.
    assign op = s1_word_reg[31:26];
    assign s1_rs = s1_word_reg[25:21];
    assign s1_rt = s1_word_reg[20:16];
    assign s1_rd = s1_word_reg[15:11];
    assign imm_ext = {{16{s1_word_reg[15]}}, s1_word_reg[15:0]};

    always_comb
    begin
        is_arith = 1'b1;
        is_imm = 1'b0;
        is_sub = 1'b0;
        is_mul = 1'b0;
        case (op)
            aie_pkg::OP_ADD:  ;
            aie_pkg::OP_SUB:  is_sub = 1'b1;
            aie_pkg::OP_MUL:  is_mul = 1'b1;
            aie_pkg::OP_ADDI: is_imm = 1'b1;
            aie_pkg::OP_SUBI:
            begin
                is_imm = 1'b1;
                is_sub = 1'b1;
            end
            aie_pkg::OP_MULI:
            begin
                is_imm = 1'b1;
                is_mul = 1'b1;
            end
            default: is_arith = 1'b0;
        endcase
        // The all-zero word is a no-op even though its opcode field reads as ADD.
        if (s1_word_reg == 32'd0)
        begin
            is_arith = 1'b0;
        end
    end

    // Operands: the bypass wins over the memory read, which missed the write made
    // at the edge this instruction entered the execute stage.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_dest_reg == s1_rs))
        begin
            opnd_a = fwd_value_reg;
        end
        else
        begin
            opnd_a = s1_rs_ok_reg ? s1_rs_data_reg : 32'd0;
        end
        if (fwd_valid_reg && (fwd_dest_reg == s1_rt))
        begin
            opnd_rt = fwd_value_reg;
        end
        else
        begin
            opnd_rt = s1_rt_ok_reg ? s1_rt_data_reg : 32'd0;
        end
    end

    assign opnd_b = is_imm ? imm_ext : opnd_rt;
    assign sum = opnd_a + (is_sub ? ~opnd_b : opnd_b) + {31'd0, is_sub};
    assign product = opnd_a * opnd_b;
    assign value = is_mul ? product : sum;

    assign dest = is_imm ? s1_rt : s1_rd;
    assign dest_idx = dest[IDX_W-1:0];
    assign dest_in_range = ({1'b0, dest} < REG_LIMIT);
    assign done = is_arith && dest_in_range;

    // A slot never changes once given, so the bypassed slot of the write just ahead
    // stands in for a slot read that missed that write.
    assign first = done && !changed_mask_reg[dest_idx];
    assign slot = first ? change_count_reg[aie_pkg::SLOT_W-1:0] :
                  (fwd_valid_reg && (fwd_dest_reg == dest)) ? fwd_slot_reg : s1_slot_reg;

    assign instr_total_next = instr_total_reg + 32'd1;
    assign arith_total_next = is_arith ? arith_total_reg + 32'd1 : arith_total_reg;
    assign change_count_next = first ? change_count_reg + 6'd1 : change_count_reg;

    // Register file write port and slot storage; no reset on the data.
    always_ff @(posedge clk)
    begin
        if (s1_move && done)
        begin
            rf_mem[dest_idx] <= value;
            if (first)
            begin
                slot_of_reg[dest_idx] <= change_count_reg[aie_pkg::SLOT_W-1:0];
            end
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            executed_reg <= done;
            dest_reg_reg <= done ? dest : 5'd0;
            dest_value_reg <= done ? value : 32'd0;
            first_change_reg <= first;
            change_slot_reg <= done ? slot : 5'd0;
            instructions_seen_reg <= instr_total_next;
            arithmetic_seen_reg <= arith_total_next;
        end
        if (s1_move && done)
        begin
            fwd_dest_reg <= dest;
            fwd_value_reg <= value;
            fwd_slot_reg <= slot;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_valid_reg <= '0;
            changed_mask_reg <= '0;
            change_count_reg <= '0;
            instr_total_reg <= '0;
            arith_total_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                instr_total_reg <= instr_total_next;
                arith_total_reg <= arith_total_next;
                change_count_reg <= change_count_next;
                if (done)
                begin
                    fwd_valid_reg <= 1'b1;
                    rf_valid_reg[dest_idx] <= 1'b1;
                    changed_mask_reg[dest_idx] <= 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign executed = executed_reg;
    assign dest_reg = dest_reg_reg;
    assign dest_value = dest_value_reg;
    assign first_change = first_change_reg;
    assign change_slot = change_slot_reg;
    assign instructions_seen = instructions_seen_reg;
    assign arithmetic_seen = arithmetic_seen_reg;

endmodule

/* rtl/aie_checker.sv */
// Port-level checks for the arithmetic instruction execute block, with its bind.
// Depends only on the ports of arith_instruction_execute.

module aie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        executed,
    input logic [4:0]  dest_reg,
    input logic [31:0] dest_value,
    input logic        first_change,
    input logic [4:0]  change_slot,
    input logic [31:0] instructions_seen
);

    logic [31:0] last_seen_reg;

    // Tracks the instruction count of the last result beat taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_seen_reg <= instructions_seen;
        end
    end

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dest_value) && $stable(dest_reg))
    else $error("result beat changed while stalled");

    // Every instruction yields exactly one result, in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> instructions_seen == last_seen_reg + 32'd1)
    else $error("result beat lost, repeated or out of order");

    // A result with no register write carries zero write fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !executed |->
            dest_reg == 5'd0 && dest_value == 32'd0 && change_slot == 5'd0)
    else $error("non-writing result carries write fields");

    // A first write implies a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_change |-> executed)
    else $error("first write flagged without a write");

endmodule

bind arith_instruction_execute aie_checker u_aie_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .executed(executed),
    .dest_reg(dest_reg),
    .dest_value(dest_value),
    .first_change(first_change),
    .change_slot(change_slot),
    .instructions_seen(instructions_seen)
);
